FILE: src/window_readout_record_packer_defines.svh
// ----------------------------------------------------------------------------
// Window readout record packer: assertion macros
// Shared property forms for the assertions of the record packer.
// ----------------------------------------------------------------------------
`ifndef WINDOW_READOUT_RECORD_PACKER_DEFINES_SVH
`define WINDOW_READOUT_RECORD_PACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/wrp_pkg.sv
// ----------------------------------------------------------------------------
// Window readout record packer package
// Constants, command codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package wrp_pkg;

  // Default number of slot index bits (store depth is a power of two).
  localparam int SLOT_BITS_DEFAULT = 6;

  // Field widths of one input item and one record.
  localparam int SLOT_IN_BITS = 6;
  localparam int HIGH_BITS    = 48;
  localparam int LOW_BITS     = 64;
  localparam int ENTRY_BITS   = HIGH_BITS + LOW_BITS;
  localparam int TIME_BITS    = 8;
  localparam int WORD_BITS    = 32;
  localparam int OFF_BITS     = 11;
  localparam int TAG_BITS     = 8;

  // Configuration port geometry.
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // Register indexes (word address bit 2).
  localparam logic REG_RECORD_TAG = 1'b0;

  // Command codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_TRIGGER = 1'b1;

  // Word pattern of the closing record.
  localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_TEST,
    ST_WAIT,
    ST_CLOSE,
    ST_WAIT_LAST
  } state_t;

endpackage

FILE: src/window_readout_record_packer.sv
// After reset the block runs a clearing pass over all 2**SLOT_BITS slots (64
// at the default depth) that zeroes the hit store; item_ready stays low
// meanwhile, while the configuration port works as usual. A write item is
// written to the store as it is taken. A trigger item walks the store from
// its start slot up to, but not including, its stop slot over the single
// store read port: for each walked slot one step reads the entry into a
// register and the next tests it; each record is held until the output side
// takes it, and the closing record follows the walk. The longest walk of the
// default store covers 63 slots. The block takes the next item only after
// the closing record of a trigger has been taken.
`include "window_readout_record_packer_defines.svh"

// ----------------------------------------------------------------------------
// Window readout record packer
// Hit store with a trigger sequencer that packs nonzero entries into records.
// ----------------------------------------------------------------------------
module window_readout_record_packer #(
  parameter int SLOT_BITS = wrp_pkg::SLOT_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wrp_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [wrp_pkg::DATA_BITS-1:0]     pwdata,
  output logic [wrp_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  // Input items.
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              command,
  input  logic [wrp_pkg::SLOT_IN_BITS-1:0]  write_slot,
  input  logic [wrp_pkg::HIGH_BITS-1:0]     entry_high,
  input  logic [wrp_pkg::LOW_BITS-1:0]      entry_low,
  input  logic [wrp_pkg::TIME_BITS-1:0]     window_start,
  input  logic [wrp_pkg::TIME_BITS-1:0]     window_stop,
  // Result items.
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [wrp_pkg::WORD_BITS-1:0]     word0,
  output logic [wrp_pkg::WORD_BITS-1:0]     word1,
  output logic [wrp_pkg::WORD_BITS-1:0]     word2,
  output logic [wrp_pkg::WORD_BITS-1:0]     word3,
  output logic [wrp_pkg::WORD_BITS-1:0]     word4,
  output logic                              last_record
);

  import wrp_pkg::*;

  localparam int DEPTH = 1 << SLOT_BITS;

  state_t                  state;
  state_t                  state_next;
  logic [SLOT_BITS-1:0]    slot;
  logic [SLOT_BITS-1:0]    slot_next;
  logic [SLOT_BITS-1:0]    start_slot;
  logic [SLOT_BITS-1:0]    stop_slot;
  logic [SLOT_BITS-1:0]    slot_plus;
  logic [SLOT_BITS-1:0]    in_start;
  logic [SLOT_BITS-1:0]    in_stop;
  logic [TAG_BITS-1:0]     record_tag;
  logic [ENTRY_BITS-1:0]   hit_store [DEPTH];
  logic [ENTRY_BITS-1:0]   rd_q;
  logic                    mem_we;
  logic [SLOT_BITS-1:0]    mem_waddr;
  logic [ENTRY_BITS-1:0]   mem_wdata;
  logic                    item_accept;
  logic                    result_accept;
  logic                    cfg_write;
  logic                    load_data;
  logic                    load_close;
  logic [SLOT_BITS-1:0]    offset;

  // Configuration register: written on the access phase, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_tag <= '0;
    end else if (cfg_write && (paddr[2] == REG_RECORD_TAG)) begin
      record_tag <= pwdata[TAG_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RECORD_TAG) begin
      prdata = {{(DATA_BITS-TAG_BITS){1'b0}}, record_tag};
    end
  end

  // Handshakes and slot arithmetic.
  assign item_ready    = (state == ST_IDLE);
  assign item_accept   = item_valid && item_ready;
  assign result_accept = result_valid && result_ready;
  assign in_start      = SLOT_BITS'(window_start[TIME_BITS-1:2]);
  assign in_stop       = SLOT_BITS'(window_stop[TIME_BITS-1:2]);
  assign slot_plus     = slot + SLOT_BITS'(1);
  assign offset        = slot - start_slot;

  // Sequencer state and walk registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      slot       <= '0;
      start_slot <= '0;
      stop_slot  <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      if (item_accept && (command == CMD_TRIGGER)) begin
        start_slot <= in_start;
        stop_slot  <= in_stop;
      end
    end
  end

  // Next state, store write port and output loads.
  always_comb begin
    state_next = state;
    slot_next  = slot;
    mem_we     = 1'b0;
    mem_waddr  = slot;
    mem_wdata  = '0;
    load_data  = 1'b0;
    load_close = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        slot_next = slot_plus;
        if (slot == SLOT_BITS'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_accept) begin
          if (command == CMD_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = SLOT_BITS'(write_slot);
            mem_wdata = {entry_high, entry_low};
          end else begin
            slot_next  = in_start;
            state_next = (in_start == in_stop) ? ST_CLOSE : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (|rd_q) begin
          load_data  = 1'b1;
          state_next = ST_WAIT;
        end else begin
          slot_next  = slot_plus;
          state_next = (slot_plus == stop_slot) ? ST_CLOSE : ST_FETCH;
        end
      end
      ST_WAIT: begin
        if (result_accept) begin
          slot_next  = slot_plus;
          state_next = (slot_plus == stop_slot) ? ST_CLOSE : ST_FETCH;
        end
      end
      ST_CLOSE: begin
        load_close = 1'b1;
        state_next = ST_WAIT_LAST;
      end
      ST_WAIT_LAST: begin
        if (result_accept) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hit store: one write port, one registered read port at the walk slot.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hit_store[mem_waddr] <= mem_wdata;
    end
    rd_q <= hit_store[slot];
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_data || load_close) begin
      result_valid <= 1'b1;
    end else if (result_accept) begin
      result_valid <= 1'b0;
    end
  end

  // Output record register.
  always_ff @(posedge clk) begin
    if (load_close) begin
      word0       <= ALL_ONES;
      word1       <= ALL_ONES;
      word2       <= ALL_ONES;
      word3       <= ALL_ONES;
      word4       <= ALL_ONES;
      last_record <= 1'b1;
    end else if (load_data) begin
      word0       <= {1'b1, record_tag[TAG_BITS-1:4], OFF_BITS'(offset), 16'h0000};
      word1       <= {13'h0000, rd_q[111:93]};
      word2       <= {1'b0, rd_q[92:62]};
      word3       <= {1'b0, rd_q[61:31]};
      word4       <= {1'b0, rd_q[30:0]};
      last_record <= 1'b0;
    end
  end

  // Assertions.
  `WRP_ASSERT_SAME(a_idle_no_result, item_ready, !result_valid,
                   "Item taken while a record is pending")
  `WRP_ASSERT_SAME(a_close_all_ones, result_valid && last_record,
                   (word0 == ALL_ONES) && (word4 == ALL_ONES),
                   "Closing record is not all ones")
  `WRP_ASSERT_SAME(a_data_format, result_valid && !last_record,
                   word0[31] && (word0[15:0] == 16'h0000) && !word2[31],
                   "Data record format broken")
  `WRP_ASSERT_NEXT(a_empty_window,
                   item_accept && (command == CMD_TRIGGER) && (in_start == in_stop),
                   state == ST_CLOSE,
                   "Empty window did not go straight to the closing record")

endmodule
